// ----- hdl/atb_pkg.sv -----
// ----------------------------------------------------------------------------
// atb_pkg
// Shared types and constants for the alarm timer bank.
// ----------------------------------------------------------------------------
package atb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int MASK_W         = 8;
  localparam int IDX_W          = 3;
  localparam int HOUR_W         = 5;
  localparam int MIN_W          = 6;
  localparam int SEC_W          = 6;
  localparam int TIME_W         = HOUR_W + MIN_W + SEC_W;

  localparam logic [1:0] FN_SET     = 2'd0;
  localparam logic [1:0] FN_STOP    = 2'd1;
  localparam logic [1:0] FN_DISABLE = 2'd2;
  localparam logic [1:0] FN_TICK    = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_PLAY  = 2'd1;
  localparam logic [1:0] CMD_PAUSE = 2'd2;

  typedef enum logic [2:0] {
    MODE_DISABLED  = 3'b001,
    MODE_IDLE      = 3'b010,
    MODE_TRIGGERED = 3'b100
  } mode_t;

  typedef struct packed {
    logic              set_en;
    logic              stop_en;
    logic              dis_en;
    logic              tick_en;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] sum;
  } atb_cmd_t;

  typedef struct packed {
    logic fired;
    logic cleared;
  } atb_stat_t;

endpackage

// ----- hdl/atb_time_add.sv -----
// ----------------------------------------------------------------------------
// atb_time_add
// Adds a duration to a time of day with carries and a 24 hour wrap.
// ----------------------------------------------------------------------------
module atb_time_add (
  input  logic [atb_pkg::HOUR_W-1:0] now_hour,
  input  logic [atb_pkg::MIN_W-1:0]  now_minute,
  input  logic [atb_pkg::SEC_W-1:0]  now_second,
  input  logic [atb_pkg::HOUR_W-1:0] dur_hour,
  input  logic [atb_pkg::MIN_W-1:0]  dur_minute,
  input  logic [atb_pkg::SEC_W-1:0]  dur_second,
  output logic [atb_pkg::TIME_W-1:0] sum
);
  import atb_pkg::*;

  logic [6:0] s_raw;
  logic [7:0] m_raw;
  logic [6:0] h_raw;
  logic [1:0] s_carry;
  logic [1:0] m_carry;
  logic [6:0] s_mod;
  logic [7:0] m_mod;
  logic [6:0] h_mod;

  assign s_raw = {1'b0, now_second} + {1'b0, dur_second};

  always_comb begin
    if (s_raw >= 7'd120) begin
      s_carry = 2'd2;
      s_mod   = s_raw - 7'd120;
    end else if (s_raw >= 7'd60) begin
      s_carry = 2'd1;
      s_mod   = s_raw - 7'd60;
    end else begin
      s_carry = 2'd0;
      s_mod   = s_raw;
    end
  end

  assign m_raw = {2'b00, now_minute} + {2'b00, dur_minute} + {6'd0, s_carry};

  always_comb begin
    if (m_raw >= 8'd120) begin
      m_carry = 2'd2;
      m_mod   = m_raw - 8'd120;
    end else if (m_raw >= 8'd60) begin
      m_carry = 2'd1;
      m_mod   = m_raw - 8'd60;
    end else begin
      m_carry = 2'd0;
      m_mod   = m_raw;
    end
  end

  assign h_raw = {2'b00, now_hour} + {2'b00, dur_hour} + {5'd0, m_carry};

  always_comb begin
    if (h_raw >= 7'd48) begin
      h_mod = h_raw - 7'd48;
    end else if (h_raw >= 7'd24) begin
      h_mod = h_raw - 7'd24;
    end else begin
      h_mod = h_raw;
    end
  end

  assign sum = {h_mod[HOUR_W-1:0], m_mod[MIN_W-1:0], s_mod[SEC_W-1:0]};

endmodule

// ----- hdl/atb_timer_slot.sv -----
// ----------------------------------------------------------------------------
// atb_timer_slot
// One alarm timer: target time, mode, and compare against the current time.
// ----------------------------------------------------------------------------
module atb_timer_slot #(
  parameter int SLOT_ID = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  atb_pkg::atb_cmd_t  cmd,
  output atb_pkg::atb_stat_t stat
);
  import atb_pkg::*;

  mode_t             mode;
  mode_t             mode_next;
  logic [TIME_W-1:0] target;
  logic              sel;

  assign sel = cmd_valid && (32'(cmd.idx) == SLOT_ID);

  assign stat.fired   = cmd_valid && cmd.tick_en && (mode == MODE_IDLE) && (target == cmd.now);
  assign stat.cleared = cmd_valid && cmd.stop_en && (mode == MODE_TRIGGERED);

  always_comb begin
    mode_next = mode;
    if (sel && cmd.set_en) begin
      mode_next = MODE_IDLE;
    end else if (sel && cmd.dis_en) begin
      mode_next = MODE_DISABLED;
    end else if (stat.cleared) begin
      mode_next = MODE_IDLE;
    end else if (stat.fired) begin
      mode_next = MODE_TRIGGERED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DISABLED;
    end else begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.set_en) begin
      target <= cmd.sum;
    end
  end

endmodule

// ----- hdl/alarm_timer_bank.sv -----
// ----------------------------------------------------------------------------
// alarm_timer_bank
// Bank of alarm timers with set, stop, disable and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge where start is high and busy is
//   low. busy is low except while rst is held, so one beat can be taken in
//   every cycle. The beat is registered, decoded, applied to every timer slot
//   in parallel and its answer registered.
//   Each beat gives exactly one answer: done is high for one cycle with
//   audio_cmd and fired_mask valid in that cycle. The beat is held in start_q
//   and the input registers, its answer in the done, audio_cmd and
//   fired_mask registers; throughput is one beat per cycle, set by the single
//   pass through the slot compare and mode update. Back-to-back beats see the
//   timer state left by the one before.
//   Reset clears all timers to disabled and drops done; a command in flight
//   is lost. The receiver cannot stall: an answer not taken in its done
//   cycle is gone.
// ----------------------------------------------------------------------------
module alarm_timer_bank #(
  parameter int NUM_TIMERS = atb_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func,
  input  logic [atb_pkg::IDX_W-1:0]   timer_index,
  input  logic [atb_pkg::HOUR_W-1:0]  dur_hour,
  input  logic [atb_pkg::MIN_W-1:0]   dur_minute,
  input  logic [atb_pkg::SEC_W-1:0]   dur_second,
  input  logic [atb_pkg::HOUR_W-1:0]  now_hour,
  input  logic [atb_pkg::MIN_W-1:0]   now_minute,
  input  logic [atb_pkg::SEC_W-1:0]   now_second,
  output logic                        done,
  output logic [1:0]                  audio_cmd,
  output logic [atb_pkg::MASK_W-1:0]  fired_mask
);
  import atb_pkg::*;

  logic              start_q;
  logic [1:0]        func_q;
  logic [IDX_W-1:0]  idx_q;
  logic [HOUR_W-1:0] dh_q;
  logic [MIN_W-1:0]  dm_q;
  logic [SEC_W-1:0]  ds_q;
  logic [HOUR_W-1:0] nh_q;
  logic [MIN_W-1:0]  nm_q;
  logic [SEC_W-1:0]  ns_q;

  logic [TIME_W-1:0]     sum;
  logic                  idx_ok;
  atb_cmd_t              cmd;
  atb_stat_t             stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fired;
  logic [NUM_TIMERS-1:0] cleared;
  logic [MASK_W-1:0]     mask_next;
  logic [1:0]            audio_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_q <= 1'b0;
    end else begin
      start_q <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_q <= func;
      idx_q  <= timer_index;
      dh_q   <= dur_hour;
      dm_q   <= dur_minute;
      ds_q   <= dur_second;
      nh_q   <= now_hour;
      nm_q   <= now_minute;
      ns_q   <= now_second;
    end
  end

  atb_time_add u_add (
    .now_hour   (nh_q),
    .now_minute (nm_q),
    .now_second (ns_q),
    .dur_hour   (dh_q),
    .dur_minute (dm_q),
    .dur_second (ds_q),
    .sum        (sum)
  );

  assign idx_ok = 32'(idx_q) < NUM_TIMERS;

  assign cmd.set_en  = (func_q == FN_SET) && idx_ok;
  assign cmd.stop_en = (func_q == FN_STOP);
  assign cmd.dis_en  = (func_q == FN_DISABLE) && idx_ok;
  assign cmd.tick_en = (func_q == FN_TICK);
  assign cmd.idx     = idx_q;
  assign cmd.now     = {nh_q, nm_q, ns_q};
  assign cmd.sum     = sum;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_slot
    atb_timer_slot #(
      .SLOT_ID (i)
    ) u_slot (
      .clk       (clk),
      .rst       (rst),
      .cmd_valid (start_q),
      .cmd       (cmd),
      .stat      (stat[i])
    );
    assign fired[i]   = stat[i].fired;
    assign cleared[i] = stat[i].cleared;
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_TIMERS) begin : g_on
      assign mask_next[b] = fired[b];
    end else begin : g_off
      assign mask_next[b] = 1'b0;
    end
  end

  always_comb begin
    audio_next = CMD_NONE;
    case (func_q)
      FN_SET: begin
        audio_next = CMD_NONE;
      end
      FN_STOP: begin
        if (|cleared) audio_next = CMD_PAUSE;
      end
      FN_DISABLE: begin
        if (idx_ok) audio_next = CMD_PAUSE;
      end
      FN_TICK: begin
        if (|fired) audio_next = CMD_PLAY;
      end
      default: begin
        audio_next = CMD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      audio_cmd  <= CMD_NONE;
      fired_mask <= '0;
    end else begin
      done       <= start_q;
      audio_cmd  <= start_q ? audio_next : CMD_NONE;
      fired_mask <= start_q ? mask_next : '0;
    end
  end

  a_answer_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted beat produced no answer");

  a_mask_needs_play: assert property (@(posedge clk)
    (done && (fired_mask != '0)) |-> (audio_cmd == CMD_PLAY))
    else $error("fired timers without play");

  a_quiet_when_idle: assert property (@(posedge clk)
    !done |-> ((audio_cmd == CMD_NONE) && (fired_mask == '0)))
    else $error("answer ports active without done");

  a_reset_drops_done: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done after reset");

endmodule
